>>> sv/salru_pkg.sv
// Shared types, codes and constants of the set-associative LRU cache simulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package salru_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W       = $clog2(MAX_WAYS + 1);
  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int CNT_W        = 32;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [1:0] {
    ACT_FETCH  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_MODIFY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_HIT   = 2'd1,
    OUT_MISS  = 2'd2,
    OUT_EVICT = 2'd3
  } outcome_t;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd2;

  typedef struct packed {
    logic          valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd;
    logic wr;
  } ctrl_cmd_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {{(CNT_W-1){1'b0}}, inc};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

>>> sv/salru_ctrl.sv
// Controller of the cache simulator: sequences capture, row read and row update.
// Depends on salru_pkg.
module salru_ctrl import salru_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    READ,
    UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            state <= READ;
          end
        end
        READ: begin
          state <= UPDATE;
        end
        UPDATE: begin
          state <= IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy        = (state != IDLE);
  assign cmd.capture = (state == IDLE) && start;
  assign cmd.rd      = (state == READ);
  assign cmd.wr      = (state == UPDATE);

endmodule

>>> sv/salru_dpath.sv
// Datapath of the cache simulator: config registers, row memory, tag compare,
// LRU victim choice, age update and saturating counters. Depends on salru_pkg.
module salru_dpath import salru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  input  logic [1:0]           action,
  input  logic [ADDR_W-1:0]    address,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  output logic [1:0]           first_outcome,
  output logic                 second_hit,
  output logic [CNT_W-1:0]     hit_total,
  output logic [CNT_W-1:0]     miss_total,
  output logic [CNT_W-1:0]     eviction_total
);

  logic [3:0] set_bits;
  logic [3:0] ways_in_use;
  logic [4:0] block_bits;

  logic [3:0]        s_eff;
  logic [WAYS_W-1:0] ways_eff;

  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_calc;
  logic [5:0]        tag_shift;
  logic [TAG_W-1:0]  tag_calc;

  logic [1:0]       act_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  row_t             mem [SETS];
  logic [SETS-1:0]  row_valid;
  row_t             row_q;
  logic             row_ok;

  logic [MAX_WAYS-1:0] vld;
  logic [MAX_WAYS-1:0] in_use;

  logic              hit;
  logic [RANK_W-1:0] hit_way;
  logic              empty;
  logic [RANK_W-1:0] empty_way;
  logic [RANK_W-1:0] victim;
  logic [RANK_W-1:0] best;
  logic [RANK_W-1:0] chosen;
  logic [RANK_W-1:0] r;
  row_t              row_new;

  logic       is_fetch;
  logic       is_modify;
  logic [1:0] hit_inc;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 4'd4;
      ways_in_use <= 4'd1;
      block_bits  <= 5'd4;
    end else if (write_enable) begin
      case (write_index)
        REG_SET_BITS:    set_bits    <= write_data[3:0];
        REG_WAYS_IN_USE: ways_in_use <= write_data[3:0];
        REG_BLOCK_BITS:  block_bits  <= write_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits;
    if (ways_in_use == 4'd0) begin
      ways_eff = WAYS_W'(1);
    end else if (ways_in_use > 4'(MAX_WAYS)) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_W'(ways_in_use);
    end
  end

  // Address split
  always_comb begin
    shifted   = address >> block_bits;
    set_mask  = ~({SET_W{1'b1}} << s_eff);
    set_calc  = shifted[SET_W-1:0] & set_mask;
    tag_shift = {1'b0, block_bits} + {2'b00, s_eff};
    tag_calc  = tag_shift[5] ? '0 : (address >> tag_shift[4:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      set_q <= set_calc;
      tag_q <= tag_calc;
    end
  end

  // Row memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      row_q <= mem[set_q];
    end
    if (cmd.wr && !is_fetch) begin
      mem[set_q] <= row_new;
    end
  end

  // A row never written since reset reads as all lines invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_ok    <= 1'b0;
    end else begin
      if (cmd.rd) begin
        row_ok <= row_valid[set_q];
      end
      if (cmd.wr && !is_fetch) begin
        row_valid[set_q] <= 1'b1;
      end
    end
  end

  assign is_fetch  = (act_q == ACT_FETCH);
  assign is_modify = (act_q == ACT_MODIFY);

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w]    = row_ok && row_q[w].valid;
      in_use[w] = (WAYS_W'(w) < ways_eff);
    end
  end

  // Lookup, victim choice and age update
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && vld[w] && (row_q[w].tag == tag_q)) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (in_use[w] && !vld[w]) begin
        empty     = 1'b1;
        empty_way = RANK_W'(w);
      end
    end

    // Oldest line, lowest way on a tie
    victim = '0;
    best   = row_q[0].rank;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (row_q[w].rank > best)) begin
        best   = row_q[w].rank;
        victim = RANK_W'(w);
      end
    end

    if (hit) begin
      chosen = hit_way;
      r      = row_q[hit_way].rank;
    end else if (empty) begin
      chosen = empty_way;
      r      = RANK_W'(MAX_WAYS - 1);
    end else begin
      chosen = victim;
      r      = best;
    end

    for (int v = 0; v < MAX_WAYS; v++) begin
      row_new[v]       = row_q[v];
      row_new[v].valid = vld[v];
      if (RANK_W'(v) == chosen) begin
        row_new[v].valid = 1'b1;
        row_new[v].tag   = tag_q;
        row_new[v].rank  = '0;
      end else if (in_use[v] && vld[v] && (row_q[v].rank < r)) begin
        row_new[v].rank = row_q[v].rank + 1'b1;
      end
    end
  end

  // A modify's second access always hits the line just touched
  assign hit_inc = {1'b0, hit} + {1'b0, is_modify};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      first_outcome  <= OUT_NONE;
      second_hit     <= 1'b0;
    end else if (cmd.wr) begin
      if (is_fetch) begin
        first_outcome <= OUT_NONE;
        second_hit    <= 1'b0;
      end else begin
        hit_total      <= sat_add(hit_total, hit_inc);
        miss_total     <= sat_add(miss_total, {1'b0, !hit});
        eviction_total <= sat_add(eviction_total, {1'b0, !hit && !empty});
        second_hit     <= is_modify;
        if (hit) begin
          first_outcome <= OUT_HIT;
        end else if (empty) begin
          first_outcome <= OUT_MISS;
        end else begin
          first_outcome <= OUT_EVICT;
        end
      end
    end
  end

endmodule

>>> sv/set_assoc_cache_lru_sim_unit.sv
// Top level of the set-associative LRU cache simulator.
// Instantiates salru_ctrl and salru_dpath; depends on salru_pkg.
//
// A word is taken at a clock edge with start high and busy low; busy then
// stays high through the READ and UPDATE states, and done pulses for exactly
// one cycle after the UPDATE state, with the outcome and the running counts on
// the result ports. A new word can be taken in that same done cycle, but not
// while busy is high: the READ state reads the set's row, and the UPDATE state
// compares tags, picks the LRU line and writes the row back. Nothing can hold
// done off; sample the result while done is high. The valid bits of all sets
// clear at reset, so no start-up sweep is needed. Config writes are taken at
// any edge with write_enable high and must only happen while the unit is idle.
module set_assoc_cache_lru_sim_unit import salru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  input  logic [1:0]           action,
  input  logic [ADDR_W-1:0]    address,
  output logic [1:0]           first_outcome,
  output logic                 second_hit,
  output logic [CNT_W-1:0]     hit_total,
  output logic [CNT_W-1:0]     miss_total,
  output logic [CNT_W-1:0]     eviction_total,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data
);

  ctrl_cmd_t cmd;

  salru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  salru_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (action),
    .address        (address),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .first_outcome  (first_outcome),
    .second_hit     (second_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a word in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    done |-> (!second_hit || first_outcome != OUT_NONE))
    else $error("second hit reported without a first lookup");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (rst)
    eviction_total <= miss_total)
    else $error("eviction count exceeds miss count");

endmodule

>>> sim/set_assoc_cache_lru_sim_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of set_assoc_cache_lru_sim_unit: LRU cache lookups checked
// against an in-bench cache predictor. Depends on salru_pkg and the unit's RTL only.
module set_assoc_cache_lru_sim_unit_tb;
  import salru_pkg::*;

  localparam int LINES       = SETS * MAX_WAYS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS  = 1150;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [1:0]           act;
    logic [ADDR_W-1:0]    addr;
  } job_t;

  typedef struct {
    outcome_t          first;
    logic              second;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  evicts;
  } cache_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 done;
  logic [1:0]           action = '0;
  logic [ADDR_W-1:0]    address = '0;
  logic [1:0]           first_outcome;
  logic                 second_hit;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;
  logic [CNT_W-1:0]     eviction_total;
  logic                 write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] write_index = '0;
  logic [CFG_W-1:0]     write_data = '0;

  set_assoc_cache_lru_sim_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .action(action), .address(address),
    .first_outcome(first_outcome), .second_hit(second_hit),
    .hit_total(hit_total), .miss_total(miss_total), .eviction_total(eviction_total),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  always #10 clk = ~clk;

  // Predicted cache state and register copies.
  logic              line_ok   [LINES];
  logic [TAG_W-1:0]  line_tag_m[LINES];
  logic [RANK_W-1:0] line_rank [LINES];
  logic [CNT_W-1:0]  hits_seen, misses_seen, evicts_seen;
  logic [3:0]        cfg_set_bits, cfg_ways;
  logic [4:0]        cfg_block_bits;

  job_t         pending_jobs[$];
  cache_reply_t expected_replies[$];

  int errors = 0;
  int replies_checked = 0;
  int accesses_sent = 0;
  int fetches_sent = 0;
  int cfg_writes = 0;
  int cycles = 0;
  int in_flight = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Make way w the youngest; valid lines younger than it age by one.
  function automatic void age_touch(int base, int ways, int w);
    logic [RANK_W-1:0] r;
    r = line_rank[base + w];
    for (int v = 0; v < ways; v++) begin
      if (v != w && line_ok[base + v] && line_rank[base + v] < r)
        line_rank[base + v] = line_rank[base + v] + 1'b1;
    end
    line_rank[base + w] = '0;
  endfunction

  function automatic outcome_t cache_probe(int set_i, logic [TAG_W-1:0] tag_v, int ways);
    int base, victim;
    logic [RANK_W-1:0] best;
    base = set_i * MAX_WAYS;
    for (int w = 0; w < ways; w++) begin
      if (line_ok[base + w] && line_tag_m[base + w] == tag_v) begin
        age_touch(base, ways, w);
        hits_seen = sat_bump(hits_seen);
        return OUT_HIT;
      end
    end
    for (int w = 0; w < ways; w++) begin
      if (!line_ok[base + w]) begin
        line_ok[base + w] = 1'b1;
        line_tag_m[base + w] = tag_v;
        line_rank[base + w] = RANK_W'(MAX_WAYS - 1);
        age_touch(base, ways, w);
        misses_seen = sat_bump(misses_seen);
        return OUT_MISS;
      end
    end
    // Set full: oldest line goes, lowest way on a tie.
    victim = 0;
    best = line_rank[base];
    for (int w = 1; w < ways; w++) begin
      if (line_rank[base + w] > best) begin
        best = line_rank[base + w];
        victim = w;
      end
    end
    line_tag_m[base + victim] = tag_v;
    age_touch(base, ways, victim);
    misses_seen = sat_bump(misses_seen);
    evicts_seen = sat_bump(evicts_seen);
    return OUT_EVICT;
  endfunction

  function automatic cache_reply_t predict_access(logic [1:0] act, logic [ADDR_W-1:0] addr);
    cache_reply_t r;
    int s, ways, b;
    logic [ADDR_W-1:0] set_v, tag_v;
    s = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
    ways = (cfg_ways == 0) ? 1 : (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
    b = cfg_block_bits;
    set_v = (b < 32) ? ((addr >> b) & ((32'd1 << s) - 32'd1)) : 32'd0;
    tag_v = (b + s < 32) ? (addr >> (b + s)) : 32'd0;
    r.first = OUT_NONE;
    r.second = 1'b0;
    if (act != ACT_FETCH) begin
      r.first = cache_probe(int'(set_v), tag_v, ways);
      if (act == ACT_MODIFY)
        r.second = (cache_probe(int'(set_v), tag_v, ways) == OUT_HIT);
    end
    r.hits = hits_seen;
    r.misses = misses_seen;
    r.evicts = evicts_seen;
    return r;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_SET_BITS:    cfg_set_bits = data[3:0];
      REG_WAYS_IN_USE: cfg_ways = data[3:0];
      REG_BLOCK_BITS:  cfg_block_bits = data;
      default: ;  // unmapped index: drop
    endcase
  endfunction

  task automatic push_access(action_t act, logic [ADDR_W-1:0] addr);
    job_t j;
    j = '{is_cfg: 1'b0, idx: '0, data: '0, act: act, addr: addr};
    pending_jobs.push_back(j);
  endtask

  // Bit 4 is ignored by the 4-bit registers; drive it at random there.
  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    job_t j;
    if (idx != REG_BLOCK_BITS)
      data[4] = 1'($urandom_range(0, 1));
    j = '{is_cfg: 1'b1, idx: idx, data: data, act: ACT_FETCH, addr: '0};
    pending_jobs.push_back(j);
  endtask

  task automatic push_setting(int s, int w, int b);
    push_cfg(REG_SET_BITS, CFG_W'(s));
    push_cfg(REG_WAYS_IN_USE, CFG_W'(w));
    push_cfg(REG_BLOCK_BITS, CFG_W'(b));
  endtask

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    $display("MISMATCH reply %0d %s: got %h expected %h", replies_checked, what, got, want);
    errors++;
  endtask

  // Driver: bursts of words with random gaps; register writes only when idle.
  logic                 took, nx_start, nx_we;
  logic [1:0]           nx_act;
  logic [ADDR_W-1:0]    nx_addr;
  logic [CFG_IDX_W-1:0] nx_idx;
  logic [CFG_W-1:0]     nx_data;
  job_t                 job_now;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      write_enable <= 1'b0;
      action <= '0;
      address <= '0;
      write_index <= '0;
      write_data <= '0;
      for (int i = 0; i < LINES; i++) begin
        line_ok[i] = 1'b0;
        line_tag_m[i] = '0;
        line_rank[i] = '0;
      end
      hits_seen = '0;
      misses_seen = '0;
      evicts_seen = '0;
      cfg_set_bits = 4'd4;
      cfg_ways = 4'd1;
      cfg_block_bits = 5'd4;
      in_flight = 0;
      idle_cycles = 0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      took = start && !busy;
      nx_start = start;
      nx_act = action;
      nx_addr = address;
      nx_we = 1'b0;
      nx_idx = write_index;
      nx_data = write_data;
      if (took) begin
        job_now = pending_jobs.pop_front();
        expected_replies.push_back(predict_access(job_now.act, job_now.addr));
        if (job_now.act == ACT_FETCH) fetches_sent++;
        else accesses_sent++;
        nx_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 40);
        end
      end
      in_flight = in_flight + (took ? 1 : 0) - (done ? 1 : 0);
      if (in_flight != 0 || start) idle_cycles = 0;
      else idle_cycles++;
      if (!nx_start && pending_jobs.size() != 0) begin
        if (pending_jobs[0].is_cfg) begin
          // Hold until every word in flight has come back.
          if (in_flight == 0 && !start && idle_cycles >= 3) begin
            job_now = pending_jobs.pop_front();
            nx_we = 1'b1;
            nx_idx = job_now.idx;
            nx_data = job_now.data;
            apply_config(job_now.idx, job_now.data);
            cfg_writes++;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          nx_start = 1'b1;
          nx_act = pending_jobs[0].act;
          nx_addr = pending_jobs[0].addr;
        end
      end
      start <= nx_start;
      action <= nx_act;
      address <= nx_addr;
      write_enable <= nx_we;
      write_index <= nx_idx;
      write_data <= nx_data;
    end
  end

  // Monitor: each done word against the oldest prediction.
  cache_reply_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected done", '0, '0);
      end else begin
        want = expected_replies.pop_front();
        if (first_outcome !== want.first)
          report_mismatch("first_outcome", CNT_W'(first_outcome), CNT_W'(want.first));
        if (second_hit !== want.second)
          report_mismatch("second_hit", CNT_W'(second_hit), CNT_W'(want.second));
        if (hit_total !== want.hits)
          report_mismatch("hit_total", hit_total, want.hits);
        if (miss_total !== want.misses)
          report_mismatch("miss_total", miss_total, want.misses);
        if (eviction_total !== want.evicts)
          report_mismatch("eviction_total", eviction_total, want.evicts);
        replies_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending_jobs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  logic [ADDR_W-1:0] addr_pool[16];
  logic [ADDR_W-1:0] off_mask, a;
  int phase, pool_n, n, sel, gen_b, random_ops;
  action_t act;

  initial begin
    // Reset setting: 16 sets, one way, 16-byte blocks.
    push_access(ACT_FETCH, 32'h0000_0000);
    push_access(ACT_FETCH, 32'hFFFF_FFFF);
    push_access(ACT_LOAD, 32'h0000_0000);
    push_access(ACT_LOAD, 32'h0000_0004);
    push_access(ACT_STORE, 32'h0000_0010);
    push_access(ACT_MODIFY, 32'h0000_0100);
    push_access(ACT_LOAD, 32'h0000_0000);
    push_access(ACT_STORE, 32'hFFFF_FFFF);
    push_access(ACT_MODIFY, 32'hFFFF_FFFF);
    // One set of four ways: fill, reuse, then walk the LRU order.
    push_setting(0, 4, 0);
    for (int i = 1; i <= 4; i++) push_access(ACT_LOAD, ADDR_W'(i));
    push_access(ACT_LOAD, 32'd1);
    push_access(ACT_LOAD, 32'd5);
    push_access(ACT_STORE, 32'd2);
    push_access(ACT_MODIFY, 32'd6);
    // Shrink the ways with lines still resident.
    push_cfg(REG_WAYS_IN_USE, 5'd2);
    push_access(ACT_LOAD, 32'd3);
    push_access(ACT_LOAD, 32'd1);
    // Zero ways acts as one; offset of 31 bits leaves set 0 and address bit 31 as the tag.
    push_cfg(REG_WAYS_IN_USE, 5'd0);
    push_cfg(REG_BLOCK_BITS, 5'd31);
    push_cfg(2'd3, 5'd17);
    push_access(ACT_LOAD, 32'h1234_5678);
    push_access(ACT_STORE, 32'h0000_0000);

    random_ops = 0;
    phase = 0;
    while (random_ops < RANDOM_OPS) begin
      case (phase)
        0: push_setting(0, 8, 0);
        1: push_setting(8, 8, 24);
        2: push_setting(15, 15, 31);
        3: push_setting(8, 0, 5);
        4: push_setting(3, 2, 24);
        5: push_setting(8, 1, 30);
        6: push_setting(0, 1, 0);
        default: begin
          push_cfg(REG_SET_BITS, CFG_W'(($urandom_range(0, 4) == 0) ?
                                 $urandom_range(0, 15) : $urandom_range(0, 6)));
          push_cfg(REG_WAYS_IN_USE, CFG_W'(($urandom_range(0, 4) == 0) ?
                                    $urandom_range(0, 15) : $urandom_range(1, 8)));
          push_cfg(REG_BLOCK_BITS, CFG_W'(($urandom_range(0, 4) == 0) ?
                                   $urandom_range(0, 31) : $urandom_range(0, 12)));
          if ($urandom_range(0, 5) == 0) push_cfg(2'd3, CFG_W'($urandom));
        end
      endcase
      // Block bits of the setting just queued, for in-block offsets.
      gen_b = pending_jobs[$].data;
      for (int i = 0; i < pending_jobs.size(); i++)
        if (pending_jobs[i].is_cfg && pending_jobs[i].idx == REG_BLOCK_BITS)
          gen_b = pending_jobs[i].data;
      off_mask = (gen_b >= 32) ? '1 : ((32'd1 << gen_b) - 32'd1);
      pool_n = $urandom_range(2, 16);
      for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
      n = $urandom_range(40, 110);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) a = addr_pool[$urandom_range(0, pool_n - 1)] ^ ($urandom & off_mask);
        else if (sel < 9) a = $urandom;
        else a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        act = ($urandom_range(0, 9) == 0) ? ACT_FETCH : action_t'($urandom_range(1, 3));
        random_ops++;
        push_access(act, a);
      end
      phase++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_jobs.size() != 0 || start || in_flight != 0) @(negedge clk);
    repeat (6) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("replies never seen", CNT_W'(expected_replies.size()), '0);
    $display("covered %0d data accesses and %0d fetches over %0d settings phases, %0d reg writes",
             accesses_sent, fetches_sent, phase, cfg_writes);
    $display("checked %0d replies: %0d hits, %0d misses, %0d evictions, %0d mismatches",
             replies_checked, hits_seen, misses_seen, evicts_seen, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
